// ----- design/assert_macros.svh -----
// Assertion helpers used by the irm_checker module of this project.
// Each use stands on a line of its own: label, clock, reset, condition, consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- design/irm_pkg.sv -----
// ----------------------------------------------------------------------------
// irm_pkg
// Types and constants shared by the I2C register master modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package irm_pkg;

   localparam logic [1:0]  FUNC_TICK  = 2'd0;
   localparam logic [1:0]  FUNC_WRITE = 2'd1;
   localparam logic [1:0]  FUNC_READ  = 2'd2;

   localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd1000;

   typedef struct packed {
      logic [1:0] func;
      logic [6:0] target_addr;
      logic [7:0] reg_offset;
      logic [7:0] wr_data;
      logic [7:0] rd_length;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_drive_low;
      logic [7:0] rd_byte;
      logic       rd_valid;
      logic       rd_last;
      logic       busy_res;
      logic       done_res;
      logic       status;
   } rsp_type;

endpackage

`default_nettype wire

// ----- design/irm_req_if.sv -----
// ----------------------------------------------------------------------------
// irm_req_if
// Request channel: command or tick with the sampled SDA level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface irm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [6:0] target_addr;
   logic [7:0] reg_offset;
   logic [7:0] wr_data;
   logic [7:0] rd_length;
   logic       sda_in;

   modport source (
      output valid, func, target_addr, reg_offset, wr_data, rd_length, sda_in,
      input  ready
   );
   modport sink (
      input  valid, func, target_addr, reg_offset, wr_data, rd_length, sda_in,
      output ready
   );
endinterface

`default_nettype wire

// ----- design/irm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// irm_rsp_if
// Response channel: bus levels, read byte and transaction status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface irm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_drive_low;
   logic [7:0] rd_byte;
   logic       rd_valid;
   logic       rd_last;
   logic       busy_res;
   logic       done_res;
   logic       status;

   modport source (
      output valid, scl_level, sda_drive_low, rd_byte, rd_valid, rd_last,
             busy_res, done_res, status,
      input  ready
   );
   modport sink (
      input  valid, scl_level, sda_drive_low, rd_byte, rd_valid, rd_last,
             busy_res, done_res, status,
      output ready
   );
endinterface

`default_nettype wire

// ----- design/irm_in_stage.sv -----
// ----------------------------------------------------------------------------
// irm_in_stage
// Input register: holds one request until the engine consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irm_in_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output      logic            in_ready,
   input  wire irm_pkg::req_type in_data,
   input  wire logic            take,
   output      logic            held_valid,
   output      irm_pkg::req_type held_data
);

   logic             valid_ff, valid_in;
   irm_pkg::req_type data_ff;

   assign in_ready = !valid_ff || take;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign held_valid = valid_ff;
   assign held_data  = data_ff;

endmodule

`default_nettype wire

// ----- design/irm_engine.sv -----
// ----------------------------------------------------------------------------
// irm_engine
// Transaction state and the one-period update of the I2C bit sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irm_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [15:0]      csr_wr_data,
   input  wire logic             go,
   input  wire irm_pkg::req_type req,
   output      irm_pkg::rsp_type rsp
);

   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_START   = 4'd1;
   localparam logic [3:0] PH_WBIT    = 4'd2;
   localparam logic [3:0] PH_WEND    = 4'd3;
   localparam logic [3:0] PH_ACKREL  = 4'd4;
   localparam logic [3:0] PH_ACKHIGH = 4'd5;
   localparam logic [3:0] PH_POLL    = 4'd6;
   localparam logic [3:0] PH_ACKLOW  = 4'd7;
   localparam logic [3:0] PH_RBIT    = 4'd8;
   localparam logic [3:0] PH_RACK    = 4'd9;
   localparam logic [3:0] PH_STOP    = 4'd10;

   localparam logic [2:0] ST_DEVW  = 3'd0;
   localparam logic [2:0] ST_REG   = 3'd1;
   localparam logic [2:0] ST_DATA  = 3'd2;
   localparam logic [2:0] ST_MID   = 3'd3;
   localparam logic [2:0] ST_DEVR  = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;
   localparam logic [2:0] ST_FINAL = 3'd6;
   localparam logic [2:0] ST_ABORT = 3'd7;

   logic [15:0] timeout_ff;
   logic [3:0]  phase_ff, phase_in;
   logic [2:0]  stage_ff, stage_in;
   logic [1:0]  sub_ff, sub_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  count_ff, count_in;
   logic [16:0] wait_ff, wait_in;
   logic [6:0]  dev_ff, dev_in;
   logic [7:0]  reg_ff, reg_in;
   logic [7:0]  data_ff, data_in;
   logic [7:0]  len_ff, len_in;
   logic        is_read_ff, is_read_in;
   logic        sda_low_ff, sda_low_in;
   logic        scl_ff, scl_in;

   logic [16:0] wait_inc;
   logic [7:0]  shift_new;
   logic [7:0]  count_inc;
   logic        last_byte;

   assign wait_inc  = wait_ff + 17'd1;
   assign shift_new = shift_ff | (8'(req.sda_in) << bit_ff);
   assign count_inc = count_ff + 8'd1;
   assign last_byte = ({1'b0, count_ff} + 9'd1) == {1'b0, len_ff};

   always_comb begin
      phase_in   = phase_ff;
      stage_in   = stage_ff;
      sub_in     = sub_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      count_in   = count_ff;
      wait_in    = wait_ff;
      dev_in     = dev_ff;
      reg_in     = reg_ff;
      data_in    = data_ff;
      len_in     = len_ff;
      is_read_in = is_read_ff;
      sda_low_in = sda_low_ff;
      scl_in     = scl_ff;
      rsp        = '0;

      if (phase_ff == PH_IDLE) begin
         if (req.func == irm_pkg::FUNC_WRITE || req.func == irm_pkg::FUNC_READ) begin
            dev_in     = req.target_addr;
            reg_in     = req.reg_offset;
            data_in    = req.wr_data;
            len_in     = req.rd_length;
            is_read_in = (req.func == irm_pkg::FUNC_READ);
            stage_in   = ST_DEVW;
            count_in   = 8'd0;
            phase_in   = PH_START;
            sub_in     = 2'd0;
            sda_low_in = 1'b0;
            scl_in     = 1'b1;
         end
      end else if (req.func == irm_pkg::FUNC_TICK) begin
         case (phase_ff)
            PH_START: begin
               if (sub_ff == 2'd0) begin
                  sub_in     = 2'd1;
                  sda_low_in = 1'b1;
               end else if (sub_ff == 2'd1) begin
                  sub_in = 2'd2;
                  scl_in = 1'b0;
               end else begin
                  shift_in = {dev_ff, stage_ff == ST_DEVR};
                  bit_in   = 3'd7;
                  phase_in = PH_WBIT;
                  sub_in   = 2'd0;
                  scl_in   = 1'b0;
               end
            end
            PH_WBIT: begin
               if (sub_ff == 2'd0) begin
                  sub_in     = 2'd1;
                  sda_low_in = !shift_ff[bit_ff];
               end else if (sub_ff == 2'd1) begin
                  sub_in = 2'd2;
                  scl_in = 1'b1;
               end else if (bit_ff == 3'd0) begin
                  phase_in = PH_WEND;
                  scl_in   = 1'b0;
               end else begin
                  bit_in = bit_ff - 3'd1;
                  sub_in = 2'd0;
                  scl_in = 1'b0;
               end
            end
            PH_WEND: begin
               phase_in   = PH_ACKREL;
               sda_low_in = 1'b0;
            end
            PH_ACKREL: begin
               phase_in = PH_ACKHIGH;
               scl_in   = 1'b1;
            end
            PH_ACKHIGH: begin
               phase_in = PH_POLL;
               wait_in  = 17'd0;
            end
            PH_POLL: begin
               if (!req.sda_in) begin
                  phase_in = PH_ACKLOW;
                  scl_in   = 1'b0;
               end else begin
                  wait_in = wait_inc;
                  // give up: drop SCL and send stop with error status
                  if (wait_inc > {1'b0, timeout_ff}) begin
                     scl_in     = 1'b0;
                     stage_in   = ST_ABORT;
                     phase_in   = PH_STOP;
                     sub_in     = 2'd0;
                     sda_low_in = 1'b1;
                  end
               end
            end
            PH_ACKLOW: begin
               case (stage_ff)
                  ST_DEVW: begin
                     stage_in = ST_REG;
                     shift_in = reg_ff;
                     bit_in   = 3'd7;
                     phase_in = PH_WBIT;
                     sub_in   = 2'd0;
                     scl_in   = 1'b0;
                  end
                  ST_REG: begin
                     if (is_read_ff) begin
                        stage_in   = ST_MID;
                        phase_in   = PH_STOP;
                        sub_in     = 2'd0;
                        sda_low_in = 1'b1;
                     end else begin
                        stage_in = ST_DATA;
                        shift_in = data_ff;
                        bit_in   = 3'd7;
                        phase_in = PH_WBIT;
                        sub_in   = 2'd0;
                        scl_in   = 1'b0;
                     end
                  end
                  ST_DATA: begin
                     stage_in   = ST_FINAL;
                     phase_in   = PH_STOP;
                     sub_in     = 2'd0;
                     sda_low_in = 1'b1;
                  end
                  default: begin
                     count_in = 8'd0;
                     if (len_ff == 8'd0) begin
                        stage_in   = ST_FINAL;
                        phase_in   = PH_STOP;
                        sub_in     = 2'd0;
                        sda_low_in = 1'b1;
                     end else begin
                        stage_in   = ST_READ;
                        phase_in   = PH_RBIT;
                        sub_in     = 2'd0;
                        bit_in     = 3'd7;
                        shift_in   = 8'd0;
                        sda_low_in = 1'b0;
                        scl_in     = 1'b1;
                     end
                  end
               endcase
            end
            PH_RBIT: begin
               if (sub_ff == 2'd0) begin
                  sub_in = 2'd1;
               end else if (sub_ff == 2'd1) begin
                  shift_in = shift_new;
                  sub_in   = 2'd2;
                  scl_in   = 1'b0;
                  if (bit_ff == 3'd0) begin
                     rsp.rd_byte  = shift_new;
                     rsp.rd_valid = 1'b1;
                     rsp.rd_last  = last_byte;
                  end
               end else if (bit_ff == 3'd0) begin
                  phase_in = PH_RACK;
                  sub_in   = 2'd0;
               end else begin
                  bit_in = bit_ff - 3'd1;
                  sub_in = 2'd0;
                  scl_in = 1'b1;
               end
            end
            PH_RACK: begin
               if (sub_ff == 2'd0) begin
                  sub_in     = 2'd1;
                  // NACK the final byte, ACK the others
                  sda_low_in = !last_byte;
               end else if (sub_ff == 2'd1) begin
                  sub_in = 2'd2;
                  scl_in = 1'b1;
               end else if (sub_ff == 2'd2) begin
                  sub_in = 2'd3;
                  scl_in = 1'b0;
               end else begin
                  count_in = count_inc;
                  if (count_inc == len_ff) begin
                     stage_in   = ST_FINAL;
                     phase_in   = PH_STOP;
                     sub_in     = 2'd0;
                     sda_low_in = 1'b1;
                  end else begin
                     phase_in   = PH_RBIT;
                     sub_in     = 2'd0;
                     bit_in     = 3'd7;
                     shift_in   = 8'd0;
                     sda_low_in = 1'b0;
                     scl_in     = 1'b1;
                  end
               end
            end
            PH_STOP: begin
               if (sub_ff == 2'd0) begin
                  sub_in = 2'd1;
                  scl_in = 1'b1;
               end else if (sub_ff == 2'd1) begin
                  sub_in     = 2'd2;
                  sda_low_in = 1'b0;
               end else if (stage_ff == ST_MID) begin
                  // repeated transaction for the read half
                  stage_in   = ST_DEVR;
                  phase_in   = PH_START;
                  sub_in     = 2'd0;
                  sda_low_in = 1'b0;
                  scl_in     = 1'b1;
               end else begin
                  rsp.done_res = 1'b1;
                  rsp.status   = (stage_ff == ST_ABORT);
                  phase_in     = PH_IDLE;
                  sub_in       = 2'd0;
                  stage_in     = ST_DEVW;
                  scl_in       = 1'b1;
                  sda_low_in   = 1'b0;
               end
            end
            default: begin
               phase_in   = PH_IDLE;
               scl_in     = 1'b1;
               sda_low_in = 1'b0;
            end
         endcase
      end

      rsp.scl_level     = scl_in;
      rsp.sda_drive_low = sda_low_in;
      rsp.busy_res      = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= irm_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         stage_ff   <= ST_DEVW;
         sub_ff     <= 2'd0;
         bit_ff     <= 3'd7;
         shift_ff   <= 8'd0;
         count_ff   <= 8'd0;
         wait_ff    <= 17'd0;
         dev_ff     <= 7'd0;
         reg_ff     <= 8'd0;
         data_ff    <= 8'd0;
         len_ff     <= 8'd0;
         is_read_ff <= 1'b0;
         sda_low_ff <= 1'b0;
         scl_ff     <= 1'b1;
      end else if (go) begin
         phase_ff   <= phase_in;
         stage_ff   <= stage_in;
         sub_ff     <= sub_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         count_ff   <= count_in;
         wait_ff    <= wait_in;
         dev_ff     <= dev_in;
         reg_ff     <= reg_in;
         data_ff    <= data_in;
         len_ff     <= len_in;
         is_read_ff <= is_read_in;
         sda_low_ff <= sda_low_in;
         scl_ff     <= scl_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/irm_out_stage.sv -----
// ----------------------------------------------------------------------------
// irm_out_stage
// Response register: holds a result until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irm_out_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire irm_pkg::rsp_type load_data,
   output      logic             free,
   output      logic             out_valid,
   input  wire logic             out_ready,
   output      irm_pkg::rsp_type out_data
);

   logic             valid_ff, valid_in;
   irm_pkg::rsp_type data_ff;

   assign free     = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- design/i2c_register_master.sv -----
// ----------------------------------------------------------------------------
// i2c_register_master
// I2C master for single register writes and multi-byte register reads.
// ----------------------------------------------------------------------------
// Every request gives exactly one response. A request is taken into an input
// register and turned into its response by the sequencer, which writes the
// response register once that register is free, and one request is accepted
// every cycle while the response side keeps up. The rate is set by the state
// update of the sequencer. A start command is honored only while no
// transaction runs; every later tick request advances the bus by one delay
// period. The acknowledge timeout register resets to 1000 and is to be
// written only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_master (
   input  wire logic  clock,
   input  wire logic  reset,
   irm_req_if.sink    req_chan,
   irm_rsp_if.source  rsp_chan,
   input  wire logic  csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   irm_pkg::req_type req_data, held_data;
   irm_pkg::rsp_type eng_rsp, out_data;
   logic             held_valid;
   logic             out_free;
   logic             go;

   assign req_data.func        = req_chan.func;
   assign req_data.target_addr = req_chan.target_addr;
   assign req_data.reg_offset  = req_chan.reg_offset;
   assign req_data.wr_data     = req_chan.wr_data;
   assign req_data.rd_length   = req_chan.rd_length;
   assign req_data.sda_in      = req_chan.sda_in;

   // advance a request only when the response register can take its result
   assign go = held_valid && out_free;

   irm_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_data    (req_data),
      .take       (go),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   irm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .go          (go),
      .req         (held_data),
      .rsp         (eng_rsp)
   );

   irm_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (go),
      .load_data (eng_rsp),
      .free      (out_free),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   assign rsp_chan.scl_level     = out_data.scl_level;
   assign rsp_chan.sda_drive_low = out_data.sda_drive_low;
   assign rsp_chan.rd_byte       = out_data.rd_byte;
   assign rsp_chan.rd_valid      = out_data.rd_valid;
   assign rsp_chan.rd_last       = out_data.rd_last;
   assign rsp_chan.busy_res      = out_data.busy_res;
   assign rsp_chan.done_res      = out_data.done_res;
   assign rsp_chan.status        = out_data.status;

endmodule

`default_nettype wire

// ----- design/irm_checker.sv -----
// ----------------------------------------------------------------------------
// irm_checker
// Port-level checks on the response stream of the I2C register master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module irm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic scl_level,
   input wire logic sda_drive_low,
   input wire logic rd_valid,
   input wire logic rd_last,
   input wire logic busy_res,
   input wire logic done_res,
   input wire logic status
);

   // hold a stalled response
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // a read byte is captured mid-transaction with SCL low
   `ASSERT_IMPLIES(a_rd_in_txn, clock, reset, rsp_valid && (rd_valid || rd_last), rd_valid && busy_res && !scl_level)
   // completion leaves the bus idle
   `ASSERT_IMPLIES(a_done_idle, clock, reset, rsp_valid && done_res, !busy_res && scl_level && !sda_drive_low)
   // error status only comes with completion
   `ASSERT_IMPLIES(a_status_done, clock, reset, rsp_valid && status, done_res)

endmodule

bind i2c_register_master irm_checker u_irm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .scl_level     (rsp_chan.scl_level),
   .sda_drive_low (rsp_chan.sda_drive_low),
   .rd_valid      (rsp_chan.rd_valid),
   .rd_last       (rsp_chan.rd_last),
   .busy_res      (rsp_chan.busy_res),
   .done_res      (rsp_chan.done_res),
   .status        (rsp_chan.status)
);

`default_nettype wire

// ----- tb/sv/i2c_register_master_checker.sv -----
// ----------------------------------------------------------------------------
// i2c_register_master_checker
// Watches the request, response and CSR ports of the I2C register master.
// Keeps its own copy of the bus sequencer, predicts the response of every
// accepted request and compares each accepted response against the oldest
// prediction. Hands the error count and the number of outstanding
// predictions to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_register_master_checker (
   input  logic        clock,
   input  logic        reset,
   irm_req_if          req_mon,
   irm_rsp_if          rsp_mon,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          fail_count,
   output int          results_seen,
   output int          expect_depth
);

   typedef enum logic [3:0] {
      BP_IDLE, BP_START, BP_WBIT, BP_WEND, BP_ACKREL, BP_ACKHIGH,
      BP_POLL, BP_ACKLOW, BP_RBIT, BP_RACK, BP_STOP
   } bus_phase_type;

   typedef enum logic [2:0] {
      XS_DEV_WR, XS_REG, XS_DATA, XS_MID, XS_DEV_RD, XS_READ, XS_FINAL, XS_ABORT
   } xfer_stage_type;

   localparam int MAX_REPORTS = 10;

   bus_phase_type  bus_phase;
   xfer_stage_type xfer_stage;
   logic [1:0]  step;
   logic [2:0]  bit_pos;
   logic [7:0]  shifter;
   logic [7:0]  bytes_done;
   logic [16:0] poll_count;
   logic [6:0]  lat_dev;
   logic [7:0]  lat_reg;
   logic [7:0]  lat_data;
   logic [7:0]  lat_len;
   logic        rd_mode;
   logic        sda_low;
   logic        scl_lvl;
   logic [15:0] timeout_limit;

   irm_pkg::rsp_type predicted_rsp_q[$];
   int          errors;
   int          checked;

   function void send_start();
      bus_phase = BP_START;
      step      = 2'd0;
      sda_low   = 1'b0;
      scl_lvl   = 1'b1;
   endfunction

   function void load_byte(input logic [7:0] b);
      shifter   = b;
      bit_pos   = 3'd7;
      bus_phase = BP_WBIT;
      step      = 2'd0;
      scl_lvl   = 1'b0;
   endfunction

   function void send_stop();
      bus_phase = BP_STOP;
      step      = 2'd0;
      sda_low   = 1'b1;
   endfunction

   function void start_read_byte();
      bus_phase = BP_RBIT;
      step      = 2'd0;
      bit_pos   = 3'd7;
      shifter   = 8'd0;
      sda_low   = 1'b0;
      scl_lvl   = 1'b1;
   endfunction

   function logic final_byte();
      return ({1'b0, bytes_done} + 9'd1) == {1'b0, lat_len};
   endfunction

   // Pick the next byte or condition once the target has acknowledged.
   function void acked();
      case (xfer_stage)
         XS_DEV_WR: begin
            xfer_stage = XS_REG;
            load_byte(lat_reg);
         end
         XS_REG: begin
            if (rd_mode) begin
               xfer_stage = XS_MID;
               send_stop();
            end else begin
               xfer_stage = XS_DATA;
               load_byte(lat_data);
            end
         end
         XS_DATA: begin
            xfer_stage = XS_FINAL;
            send_stop();
         end
         default: begin
            bytes_done = 8'd0;
            if (lat_len == 8'd0) begin
               xfer_stage = XS_FINAL;
               send_stop();
            end else begin
               xfer_stage = XS_READ;
               start_read_byte();
            end
         end
      endcase
   endfunction

   function void clear_bus();
      bus_phase     = BP_IDLE;
      xfer_stage    = XS_DEV_WR;
      step          = 2'd0;
      bit_pos       = 3'd7;
      shifter       = 8'd0;
      bytes_done    = 8'd0;
      poll_count    = 17'd0;
      lat_dev       = 7'd0;
      lat_reg       = 8'd0;
      lat_data      = 8'd0;
      lat_len       = 8'd0;
      rd_mode       = 1'b0;
      sda_low       = 1'b0;
      scl_lvl       = 1'b1;
      timeout_limit = irm_pkg::ACK_TIMEOUT_RESET;
   endfunction

   // One request moves the bus by one delay period.
   function automatic irm_pkg::rsp_type advance_i2c_bus(input irm_pkg::req_type r);
      irm_pkg::rsp_type o;
      o = '0;
      if (bus_phase == BP_IDLE) begin
         if (r.func == irm_pkg::FUNC_WRITE || r.func == irm_pkg::FUNC_READ) begin
            lat_dev    = r.target_addr;
            lat_reg    = r.reg_offset;
            lat_data   = r.wr_data;
            lat_len    = r.rd_length;
            rd_mode    = (r.func == irm_pkg::FUNC_READ);
            xfer_stage = XS_DEV_WR;
            bytes_done = 8'd0;
            send_start();
         end
      end else if (r.func == irm_pkg::FUNC_TICK) begin
         case (bus_phase)
            BP_START: begin
               if (step == 2'd0) begin
                  step    = 2'd1;
                  sda_low = 1'b1;
               end else if (step == 2'd1) begin
                  step    = 2'd2;
                  scl_lvl = 1'b0;
               end else if (xfer_stage == XS_DEV_RD) begin
                  load_byte({lat_dev, 1'b1});
               end else begin
                  load_byte({lat_dev, 1'b0});
               end
            end
            BP_WBIT: begin
               if (step == 2'd0) begin
                  step    = 2'd1;
                  sda_low = ~shifter[bit_pos];
               end else if (step == 2'd1) begin
                  step    = 2'd2;
                  scl_lvl = 1'b1;
               end else if (bit_pos == 3'd0) begin
                  bus_phase = BP_WEND;
                  scl_lvl   = 1'b0;
               end else begin
                  bit_pos = bit_pos - 3'd1;
                  step    = 2'd0;
                  scl_lvl = 1'b0;
               end
            end
            BP_WEND: begin
               bus_phase = BP_ACKREL;
               sda_low   = 1'b0;
            end
            BP_ACKREL: begin
               bus_phase = BP_ACKHIGH;
               scl_lvl   = 1'b1;
            end
            BP_ACKHIGH: begin
               bus_phase  = BP_POLL;
               poll_count = 17'd0;
            end
            BP_POLL: begin
               if (!r.sda_in) begin
                  bus_phase = BP_ACKLOW;
                  scl_lvl   = 1'b0;
               end else begin
                  poll_count = poll_count + 17'd1;
                  // give up once the high count passes the limit
                  if (poll_count > {1'b0, timeout_limit}) begin
                     scl_lvl    = 1'b0;
                     xfer_stage = XS_ABORT;
                     send_stop();
                  end
               end
            end
            BP_ACKLOW: acked();
            BP_RBIT: begin
               if (step == 2'd0) begin
                  step = 2'd1;
               end else if (step == 2'd1) begin
                  shifter[bit_pos] = shifter[bit_pos] | r.sda_in;
                  step    = 2'd2;
                  scl_lvl = 1'b0;
                  if (bit_pos == 3'd0) begin
                     o.rd_byte  = shifter;
                     o.rd_valid = 1'b1;
                     o.rd_last  = final_byte();
                  end
               end else if (bit_pos == 3'd0) begin
                  bus_phase = BP_RACK;
                  step      = 2'd0;
               end else begin
                  bit_pos = bit_pos - 3'd1;
                  step    = 2'd0;
                  scl_lvl = 1'b1;
               end
            end
            BP_RACK: begin
               if (step == 2'd0) begin
                  step    = 2'd1;
                  // NACK the final byte, ACK all others
                  sda_low = ~final_byte();
               end else if (step == 2'd1) begin
                  step    = 2'd2;
                  scl_lvl = 1'b1;
               end else if (step == 2'd2) begin
                  step    = 2'd3;
                  scl_lvl = 1'b0;
               end else begin
                  bytes_done = bytes_done + 8'd1;
                  if (bytes_done == lat_len) begin
                     xfer_stage = XS_FINAL;
                     send_stop();
                  end else begin
                     start_read_byte();
                  end
               end
            end
            BP_STOP: begin
               if (step == 2'd0) begin
                  step    = 2'd1;
                  scl_lvl = 1'b1;
               end else if (step == 2'd1) begin
                  step    = 2'd2;
                  sda_low = 1'b0;
               end else if (xfer_stage == XS_MID) begin
                  xfer_stage = XS_DEV_RD;
                  send_start();
               end else begin
                  o.done_res = 1'b1;
                  o.status   = (xfer_stage == XS_ABORT);
                  bus_phase  = BP_IDLE;
                  step       = 2'd0;
                  xfer_stage = XS_DEV_WR;
                  scl_lvl    = 1'b1;
                  sda_low    = 1'b0;
               end
            end
            default: begin
               bus_phase = BP_IDLE;
               scl_lvl   = 1'b1;
               sda_low   = 1'b0;
            end
         endcase
      end
      o.scl_level     = scl_lvl;
      o.sda_drive_low = sda_low;
      o.busy_res      = (bus_phase != BP_IDLE);
      return o;
   endfunction

   always @(posedge clock) begin
      irm_pkg::req_type req_now;
      irm_pkg::rsp_type got;
      irm_pkg::rsp_type want;
      if (reset) begin
         clear_bus();
         predicted_rsp_q.delete();
         errors  = 0;
         checked = 0;
      end else begin
         if (csr_wr_en)
            timeout_limit = csr_wr_data;
         if (req_mon.valid && req_mon.ready) begin
            req_now.func        = req_mon.func;
            req_now.target_addr = req_mon.target_addr;
            req_now.reg_offset  = req_mon.reg_offset;
            req_now.wr_data     = req_mon.wr_data;
            req_now.rd_length   = req_mon.rd_length;
            req_now.sda_in      = req_mon.sda_in;
            predicted_rsp_q.push_back(advance_i2c_bus(req_now));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.scl_level     = rsp_mon.scl_level;
            got.sda_drive_low = rsp_mon.sda_drive_low;
            got.rd_byte       = rsp_mon.rd_byte;
            got.rd_valid      = rsp_mon.rd_valid;
            got.rd_last       = rsp_mon.rd_last;
            got.busy_res      = rsp_mon.busy_res;
            got.done_res      = rsp_mon.done_res;
            got.status        = rsp_mon.status;
            checked++;
            if (predicted_rsp_q.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: response %0d arrived with no request outstanding",
                           $realtime, checked);
            end else begin
               want = predicted_rsp_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= MAX_REPORTS) begin
                     $display("%0t: response %0d mismatch", $realtime, checked);
                     $display("   expected scl %b sda_low %b byte %h valid %b last %b",
                              want.scl_level, want.sda_drive_low, want.rd_byte,
                              want.rd_valid, want.rd_last);
                     $display("            busy %b done %b status %b",
                              want.busy_res, want.done_res, want.status);
                     $display("   actual   scl %b sda_low %b byte %h valid %b last %b",
                              got.scl_level, got.sda_drive_low, got.rd_byte,
                              got.rd_valid, got.rd_last);
                     $display("            busy %b done %b status %b",
                              got.busy_res, got.done_res, got.status);
                  end
               end
            end
         end
      end
      fail_count   <= errors;
      results_seen <= checked;
      expect_depth <= predicted_rsp_q.size();
   end

endmodule

// ----- tb/sv/tb_i2c_register_master.sv -----
// ----------------------------------------------------------------------------
// tb_i2c_register_master
// Stimulus and verdict for the I2C register master. Runs directed register
// writes and reads, zero-length reads, acknowledge timeouts and commands
// issued while busy, then random transactions in several idling phases with
// different acknowledge timeouts, emulating the target through the sampled
// SDA level. Checking is done by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_i2c_register_master;

   localparam logic [1:0] FUNC_UNUSED      = 2'd3;
   localparam int         ITEMS_PER_PHASE  = 90;
   localparam int         RANDOM_PHASES    = 5;
   localparam int         HOLD_CYCLES      = 300;
   localparam int         NOISE_WINDOW     = 20;
   localparam int         END_SETTLE       = 20;

   localparam int MODE_NONE = 0;
   localparam int MODE_TX   = 1;
   localparam int MODE_RX   = 2;
   localparam int MODE_BOTH = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   int          fail_count;
   int          results_seen;
   int          expect_depth;

   int          tx_idle_pct = 0;
   int          rx_stall_pct = 0;
   int          reqs_sent = 0;
   int          done_seen = 0;
   logic [15:0] cur_timeout = irm_pkg::ACK_TIMEOUT_RESET;
   logic        hold_flip = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;

   irm_req_if req_chan ();
   irm_rsp_if rsp_chan ();

   i2c_register_master u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   i2c_register_master_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (fail_count),
      .results_seen (results_seen),
      .expect_depth (expect_depth)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb_i2c_register_master NOT OK");
      $finish;
   end

   // Response side: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_flip != hold_seen) begin
         hold_seen      <= hold_flip;
         hold_left      <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready && rsp_chan.done_res)
         done_seen <= done_seen + 1;
   end

   function automatic irm_pkg::req_type make_req(input logic [1:0] f,
                                                 input logic [6:0] dev,
                                                 input logic [7:0] ra, input logic [7:0] wd,
                                                 input logic [7:0] len, input logic sda);
      irm_pkg::req_type r;
      r.func        = f;
      r.target_addr = dev;
      r.reg_offset  = ra;
      r.wr_data     = wd;
      r.rd_length   = len;
      r.sda_in      = sda;
      return r;
   endfunction

   function automatic irm_pkg::req_type random_req(input logic [1:0] f, input int zero_pct);
      return make_req(f, 7'($urandom_range(127)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      logic'($urandom_range(99) >= zero_pct));
   endfunction

   // Hold valid high across back-to-back requests; drop it only for a gap.
   task automatic send_req(input irm_pkg::req_type r);
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < tx_idle_pct)
            @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.func        <= r.func;
      req_chan.target_addr <= r.target_addr;
      req_chan.reg_offset  <= r.reg_offset;
      req_chan.wr_data     <= r.wr_data;
      req_chan.rd_length   <= r.rd_length;
      req_chan.sda_in      <= r.sda_in;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      reqs_sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (results_seen != reqs_sent)
         @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] v);
      drain();
      cur_timeout  = v;
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         MODE_TX: begin
            tx_idle_pct  = 66;
            rx_stall_pct <= 0;
         end
         MODE_RX: begin
            tx_idle_pct  = 0;
            rx_stall_pct <= 66;
         end
         MODE_BOTH: begin
            tx_idle_pct  = 11;
            rx_stall_pct <= 11;
         end
         default: begin
            tx_idle_pct  = 0;
            rx_stall_pct <= 0;
         end
      endcase
   endtask

   // Issue one command, then tick with the emulated target's SDA until the
   // transaction reports done. Early ticks are sometimes replaced by
   // commands, which the busy block must drop.
   task automatic run_txn(input logic [1:0] f, input logic [6:0] dev,
                          input logic [7:0] ra, input logic [7:0] wd,
                          input logic [7:0] len, input int zero_pct,
                          input bit busy_cmds);
      int start;
      int n;
      start = done_seen;
      send_req(make_req(f, dev, ra, wd, len, 1'b1));
      if (busy_cmds) begin
         send_req(make_req(irm_pkg::FUNC_READ, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1));
         send_req(make_req(irm_pkg::FUNC_WRITE, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b0));
         send_req(make_req(FUNC_UNUSED, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      end
      n = 0;
      while (done_seen == start) begin
         if (n < NOISE_WINDOW && $urandom_range(15) == 0)
            send_req(random_req(2'($urandom_range(1, 3)), zero_pct));
         else
            send_req(random_req(irm_pkg::FUNC_TICK, zero_pct));
         n++;
      end
   endtask

   task automatic random_txn();
      logic [1:0] f;
      logic [7:0] len;
      int         zero_pct;
      int         pick;
      f    = $urandom_range(1) ? irm_pkg::FUNC_READ : irm_pkg::FUNC_WRITE;
      len  = 8'($urandom_range(3));
      pick = $urandom_range(2);
      zero_pct = (pick == 0) ? 50 : (pick == 1) ? 80 : 95;
      // long reads only where a weak target will almost surely abort them
      if (cur_timeout == 16'd0 && $urandom_range(7) == 0) begin
         len      = 8'($urandom_range(255));
         zero_pct = 15;
      end
      repeat ($urandom_range(2)) begin
         send_req(random_req($urandom_range(1) ? irm_pkg::FUNC_TICK : FUNC_UNUSED, 50));
      end
      run_txn(f, 7'($urandom_range(127)), 8'($urandom_range(255)),
              8'($urandom_range(255)), len, zero_pct, 1'b0);
   endtask

   initial begin
      logic [15:0] phase_timeout[RANDOM_PHASES];
      int          phase_mode[RANDOM_PHASES];
      int          phase_end;
      phase_timeout = '{16'hFFFF, 16'd3, 16'd1000, 16'd0, 16'd7};
      phase_mode    = '{MODE_NONE, MODE_TX, MODE_RX, MODE_BOTH, MODE_NONE};

      req_chan.valid       = 1'b0;
      req_chan.func        = irm_pkg::FUNC_TICK;
      req_chan.target_addr = 7'd0;
      req_chan.reg_offset  = 8'd0;
      req_chan.wr_data     = 8'd0;
      req_chan.rd_length   = 8'd0;
      req_chan.sda_in      = 1'b1;
      rsp_chan.ready       = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle ticks and the unused code do nothing.
      send_req(make_req(irm_pkg::FUNC_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0));
      send_req(make_req(irm_pkg::FUNC_TICK, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      send_req(make_req(FUNC_UNUSED, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      send_req(make_req(FUNC_UNUSED, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0));
      // Writes with all-ones and all-zero fields, commands while busy.
      run_txn(irm_pkg::FUNC_WRITE, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 100, 1'b1);
      run_txn(irm_pkg::FUNC_WRITE, 7'h00, 8'h00, 8'h00, 8'h00, 100, 1'b0);
      // Zero-length read, then a short read with mixed data.
      run_txn(irm_pkg::FUNC_READ, 7'h55, 8'hAA, 8'h00, 8'h00, 100, 1'b0);
      run_txn(irm_pkg::FUNC_READ, 7'h2A, 8'h55, 8'h5A, 8'h02, 60, 1'b0);
      // Target never acknowledges: abort with NACK status.
      write_timeout(16'd2);
      run_txn(irm_pkg::FUNC_WRITE, 7'h11, 8'h22, 8'h33, 8'h01, 0, 1'b0);
      write_timeout(16'd0);
      run_txn(irm_pkg::FUNC_READ, 7'h7F, 8'h80, 8'hFF, 8'hFF, 0, 1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_timeout(phase_timeout[p]);
         set_idling(phase_mode[p]);
         // stall the response side while requests keep coming
         if (phase_mode[p] == MODE_RX)
            hold_flip <= ~hold_flip;
         phase_end = reqs_sent + ITEMS_PER_PHASE;
         while (reqs_sent < phase_end)
            random_txn();
      end

      drain();
      repeat (END_SETTLE) @(posedge clock);
      if (fail_count == 0 && expect_depth == 0) begin
         $display("tb_i2c_register_master OK");
      end else begin
         $display("tb_i2c_register_master NOT OK");
      end
      $finish;
   end

endmodule

// ----- i2c_register_master.f -----
+incdir+design
design/irm_pkg.sv
design/irm_req_if.sv
design/irm_rsp_if.sv
design/irm_in_stage.sv
design/irm_engine.sv
design/irm_out_stage.sv
design/i2c_register_master.sv
design/irm_checker.sv
tb/sv/i2c_register_master_checker.sv
tb/sv/tb_i2c_register_master.sv
